// File: rtl/assert_macros.svh
// assertion macros shared by the pixel converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define PFAC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true out of reset
`define PFAC_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PFAC_ASSERT(label, clk, rst_n, prop, msg)
`define PFAC_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// File: rtl/pfac_pkg.sv
// types and constants for the pixel format and alpha converter
package pfac_pkg;

	localparam logic [2:0] FMT_RGBA8888    = 3'd0;
	localparam logic [2:0] FMT_RGB888      = 3'd1;
	localparam logic [2:0] FMT_ARGB32      = 3'd2;
	localparam logic [2:0] FMT_RGBA8888_SA = 3'd3;
	localparam logic [2:0] FMT_ARGB32_SA   = 3'd4;

	localparam logic [1:0] CFG_SRC_FORMAT = 2'd0;
	localparam logic [1:0] CFG_DST_FORMAT = 2'd1;

	localparam logic [1:0] CONV_NONE     = 2'd0;
	localparam logic [1:0] CONV_PREMUL   = 2'd1;
	localparam logic [1:0] CONV_STRAIGHT = 2'd2;

	localparam logic [2:0] BYTES_RGB  = 3'd3;
	localparam logic [2:0] BYTES_FULL = 3'd4;

	localparam logic [7:0] ALPHA_MAX = 8'hFF;

	localparam int NUM_CH    = 3;
	localparam int NUM_CELLS = 8;

	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] w;
	} lane_t;

	typedef struct packed {
		logic [31:0]           px;
		logic [7:0]            a;
		logic [NUM_CH-1:0][7:0] chan;
		logic [1:0]            conv;
		logic [2:0]            dst;
		logic                  pass;
		logic                  pass_rgb;
		logic                  last;
	} side_t;

	typedef struct packed {
		lane_t [NUM_CH-1:0] lane;
		logic [7:0]         dvs;
		side_t              side;
	} stage_t;

endpackage

// File: rtl/pfac_front.sv
// front stage: unpacks the source pixel and forms dividends and divisor
module pfac_front
	import pfac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [31:0] pixel_in,
	input  logic        last_pixel,
	input  logic [2:0]  src_format,
	input  logic [2:0]  dst_format,
	output logic        out_valid,
	output stage_t      out_data
);

	logic                   known;
	logic                   src_word;
	logic                   src_sa;
	logic                   dst_sa;
	logic [7:0]             alpha;
	logic [NUM_CH-1:0][7:0] chan;
	logic [1:0]             conv;
	logic [NUM_CH-1:0][15:0] prod;
	logic [NUM_CH-1:0][15:0] lin;
	logic [NUM_CH-1:0][15:0] num;
	stage_t                 next_d;
	logic                   valid_s1;
	stage_t                 data_s1;

	always_comb begin
		known = (src_format inside {[FMT_RGBA8888:FMT_ARGB32_SA]})
			&& (dst_format inside {[FMT_RGBA8888:FMT_ARGB32_SA]});
		src_word = (src_format == FMT_ARGB32) || (src_format == FMT_ARGB32_SA);
		src_sa = (src_format == FMT_RGBA8888_SA) || (src_format == FMT_ARGB32_SA);
		dst_sa = (dst_format == FMT_RGBA8888_SA) || (dst_format == FMT_ARGB32_SA);
		if (src_word) begin
			alpha   = pixel_in[31:24];
			chan[0] = pixel_in[23:16];
			chan[1] = pixel_in[15:8];
			chan[2] = pixel_in[7:0];
		end else begin
			alpha   = (src_format == FMT_RGB888) ? ALPHA_MAX : pixel_in[31:24];
			chan[0] = pixel_in[7:0];
			chan[1] = pixel_in[15:8];
			chan[2] = pixel_in[23:16];
		end
		if (!known || (src_format == dst_format)) begin
			conv = CONV_NONE;
		end else if (src_sa && !dst_sa) begin
			conv = CONV_PREMUL;
		end else if (!src_sa && dst_sa) begin
			conv = CONV_STRAIGHT;
		end else begin
			conv = CONV_NONE;
		end
		for (int i = 0; i < NUM_CH; i++) begin
			prod[i] = {8'h00, chan[i]} * {8'h00, alpha};
			lin[i]  = ({chan[i], 8'h00} - {8'h00, chan[i]}) + {8'h00, alpha} - 16'd1;
			num[i]  = (conv == CONV_PREMUL) ? prod[i] : lin[i];
			next_d.lane[i].rem = num[i][15:8];
			next_d.lane[i].w   = num[i][7:0];
		end
		next_d.dvs           = (conv == CONV_PREMUL) ? ALPHA_MAX : alpha;
		next_d.side.px       = pixel_in;
		next_d.side.a        = alpha;
		next_d.side.chan     = chan;
		next_d.side.conv     = conv;
		next_d.side.dst      = dst_format;
		next_d.side.pass     = !known || (src_format == dst_format);
		next_d.side.pass_rgb = known && (src_format == dst_format)
			&& (dst_format == FMT_RGB888);
		next_d.side.last     = last_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= next_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// File: rtl/pfac_cell.sv
// divider cell: one restoring quotient bit for each colour lane
module pfac_cell
	import pfac_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   in_valid,
	input  stage_t in_data,
	output logic   out_valid,
	output stage_t out_data
);

	logic [NUM_CH-1:0][8:0] trial;
	logic [NUM_CH-1:0][8:0] diff;
	logic [NUM_CH-1:0]      ge;
	stage_t                 next_d;
	logic                   valid_q;
	stage_t                 data_q;

	always_comb begin
		next_d = in_data;
		for (int i = 0; i < NUM_CH; i++) begin
			trial[i] = {in_data.lane[i].rem, in_data.lane[i].w[7]};
			diff[i]  = trial[i] - {1'b0, in_data.dvs};
			ge[i]    = trial[i] >= {1'b0, in_data.dvs};
			next_d.lane[i].rem = ge[i] ? diff[i][7:0] : trial[i][7:0];
			next_d.lane[i].w   = {in_data.lane[i].w[6:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= next_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: rtl/pfac_back.sv
// back stage: picks the channel results and packs the destination pixel
module pfac_back
	import pfac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  stage_t      in_data,
	output logic        out_valid,
	output logic [31:0] pixel_out,
	output logic [2:0]  pixel_bytes,
	output logic        last_out
);

	logic [NUM_CH-1:0][7:0] res;
	logic [31:0]            pix_d;
	logic [2:0]             bytes_d;
	logic                   valid_q;
	logic [31:0]            pixel_q;
	logic [2:0]             bytes_q;
	logic                   last_q;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			case (in_data.side.conv)
				CONV_PREMUL: res[i] = in_data.lane[i].w;
				CONV_STRAIGHT: begin
					if (in_data.side.a == 8'h00) begin
						res[i] = in_data.side.chan[i];
					end else if (in_data.side.chan[i] > in_data.side.a) begin
						res[i] = ALPHA_MAX;
					end else begin
						res[i] = in_data.lane[i].w;
					end
				end
				default: res[i] = in_data.side.chan[i];
			endcase
		end
		if (in_data.side.pass) begin
			pix_d   = in_data.side.pass_rgb ? {8'h00, in_data.side.px[23:0]}
				: in_data.side.px;
			bytes_d = in_data.side.pass_rgb ? BYTES_RGB : BYTES_FULL;
		end else begin
			case (in_data.side.dst)
				FMT_ARGB32, FMT_ARGB32_SA: begin
					pix_d   = {in_data.side.a, res[0], res[1], res[2]};
					bytes_d = BYTES_FULL;
				end
				FMT_RGB888: begin
					pix_d   = {8'h00, res[2], res[1], res[0]};
					bytes_d = BYTES_RGB;
				end
				default: begin
					pix_d   = {in_data.side.a, res[2], res[1], res[0]};
					bytes_d = BYTES_FULL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q <= pix_d;
			bytes_q <= bytes_d;
			last_q  <= in_data.side.last;
		end
	end

	assign out_valid   = valid_q;
	assign pixel_out   = pixel_q;
	assign pixel_bytes = bytes_q;
	assign last_out    = last_q;

endmodule

// File: rtl/pixel_format_alpha_converter.sv
// pixel format and alpha converter: config registers, pipeline of divider cells
// a beat accepted at the input passes the front stage, the divider cells and the back stage registers in order
// throughput: one pixel per cycle while the output is not stalled, the eight divider cells are fully pipelined
// empty stages fill while the output is stalled, so input stall rises only when all are full
// reset clears every stage valid and sets both format registers to RGBA8888
`include "assert_macros.svh"

module pixel_format_alpha_converter
	import pfac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [31:0] pixel_in,
	input  logic        last_pixel,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] pixel_out,
	output logic [2:0]  pixel_bytes,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	logic [2:0]         src_format_q;
	logic [2:0]         dst_format_q;
	logic [NUM_CELLS:0] stage_valid;
	stage_t             stage_data [NUM_CELLS+1];
	logic [NUM_CELLS+1:0] rdy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_format_q <= FMT_RGBA8888;
			dst_format_q <= FMT_RGBA8888;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC_FORMAT: src_format_q <= cfg_data;
				CFG_DST_FORMAT: dst_format_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ready ripples back: a stage loads when empty or when the next one loads
	assign rdy[NUM_CELLS+1] = !result_valid || !result_stall;
	for (genvar k = 0; k <= NUM_CELLS; k++) begin : g_rdy
		assign rdy[k] = !stage_valid[k] || rdy[k+1];
	end

	assign pixel_stall = !rdy[0];

	pfac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (rdy[0]),
		.in_valid   (pixel_valid),
		.pixel_in   (pixel_in),
		.last_pixel (last_pixel),
		.src_format (src_format_q),
		.dst_format (dst_format_q),
		.out_valid  (stage_valid[0]),
		.out_data   (stage_data[0])
	);

	for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
		pfac_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (rdy[k]),
			.in_valid  (stage_valid[k-1]),
			.in_data   (stage_data[k-1]),
			.out_valid (stage_valid[k]),
			.out_data  (stage_data[k])
		);
	end

	pfac_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (rdy[NUM_CELLS+1]),
		.in_valid    (stage_valid[NUM_CELLS]),
		.in_data     (stage_data[NUM_CELLS]),
		.out_valid   (result_valid),
		.pixel_out   (pixel_out),
		.pixel_bytes (pixel_bytes),
		.last_out    (last_out)
	);

	`PFAC_ASSERT(a_bytes_legal, clk, arst_n, result_valid |-> (pixel_bytes == BYTES_RGB || pixel_bytes == BYTES_FULL), "pixel_bytes out of range")
	`PFAC_ASSERT(a_rgb_top_zero, clk, arst_n, (result_valid && pixel_bytes == BYTES_RGB) |-> (pixel_out[31:24] == 8'h00), "rgb beat has nonzero top byte")
	`PFAC_NEVER(a_stall_when_empty, clk, arst_n, !result_valid && pixel_stall, "input stalled with empty output stage")
	`PFAC_ASSERT(a_cell_drain, clk, arst_n, (stage_valid[NUM_CELLS] && !result_valid) |=> result_valid, "last cell beat not taken by empty output stage")

endmodule
